// File: sv/z80bd_pkg.sv
package z80bd_pkg;

	typedef enum logic [2:0] {
		TGT_FM   = 3'd0,
		TGT_PSG  = 3'd1,
		TGT_BANK = 3'd2,
		TGT_MAIN = 3'd3,
		TGT_RAM  = 3'd4,
		TGT_OFF  = 3'd5,
		TGT_BAD  = 3'd6
	} target_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PSG_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CD_MODE    = 2'd2;

	localparam logic [15:0] PSG_MASK  = 16'hfff9;
	localparam logic [15:0] PSG_MATCH = 16'h7f11;
	localparam logic [7:0]  BANK_PAGE = 8'h60;
	localparam logic [2:0]  FM_BLOCK  = 3'b010;

	localparam int QUEUE_DEPTH = 4;

	// Decoded access as it travels from the front to the back.
	typedef struct packed {
		target_t     target;
		logic [23:0] main_address;
		logic        to_cd_map;
		logic [7:0]  forward_data;
		logic        ram_wr;
		logic        ram_rd;
	} info_t;

endpackage

// File: sv/z80bd_front.sv
module z80bd_front #(
	parameter int LOCAL_RAM_DEPTH = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [z80bd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                            cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [15:0]                     address,
	input  logic [7:0]                      write_data,
	input  logic                            q_full,
	output logic                            push,
	output z80bd_pkg::info_t                info,
	output logic [$clog2(LOCAL_RAM_DEPTH)-1:0] ram_idx
);
	import z80bd_pkg::*;

	localparam int IW = $clog2(LOCAL_RAM_DEPTH);
	localparam logic [17:0] DEPTH_W = 18'(LOCAL_RAM_DEPTH);

	logic       fm_enable_q;
	logic       psg_enable_q;
	logic       cd_mode_q;
	logic [8:0] bank_q;

	logic hit_fm, hit_psg, hit_bank, hit_win, hit_ram;
	logic [17:0] rem;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	assign hit_fm   = address[15:13] == FM_BLOCK;
	assign hit_psg  = opcode && ((address & PSG_MASK) == PSG_MATCH);
	assign hit_bank = opcode && (address[15:8] == BANK_PAGE);
	assign hit_win  = address[15];
	assign hit_ram  = address[15:14] == 2'b00;

	// Fold the mirrored offset into the RAM depth, one quotient bit a step.
	always_comb begin
		rem = {4'd0, address[13:0]};
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (DEPTH_W << k)) begin
				rem = rem - (DEPTH_W << k);
			end
		end
	end
	assign ram_idx = rem[IW-1:0];

	always_comb begin
		info = '0;
		info.target = TGT_BAD;
		if (hit_fm) begin
			if (fm_enable_q) begin
				info.target       = TGT_FM;
				info.forward_data = opcode ? write_data : 8'd0;
			end else begin
				info.target = TGT_OFF;
			end
		end else if (hit_psg) begin
			if (psg_enable_q) begin
				info.target       = TGT_PSG;
				info.forward_data = write_data;
			end else begin
				info.target = TGT_OFF;
			end
		end else if (hit_bank) begin
			info.target       = TGT_BANK;
			info.forward_data = write_data;
		end else if (hit_win) begin
			info.target       = TGT_MAIN;
			info.main_address = {bank_q, address[14:0]};
			info.to_cd_map    = cd_mode_q;
			info.forward_data = opcode ? write_data : 8'd0;
		end else if (hit_ram) begin
			info.target       = TGT_RAM;
			info.ram_wr       = opcode;
			info.ram_rd       = !opcode;
			info.forward_data = opcode ? write_data : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_enable_q  <= 1'b1;
			psg_enable_q <= 1'b1;
			cd_mode_q    <= 1'b0;
			bank_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FM_ENABLE:  fm_enable_q  <= cfg_wdata;
					CFG_PSG_ENABLE: psg_enable_q <= cfg_wdata;
					CFG_CD_MODE:    cd_mode_q    <= cfg_wdata;
					default: ;
				endcase
			end
			// Shift the data bit in from the top on a bank write.
			if (push && info.target == TGT_BANK) begin
				bank_q <= {write_data[0], bank_q[8:1]};
			end
		end
	end

endmodule

// File: sv/z80bd_queue.sv
module z80bd_queue #(
	parameter int DEPTH = 4,
	parameter int W     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/z80bd_back.sv
module z80bd_back #(
	parameter int LOCAL_RAM_DEPTH = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  z80bd_pkg::info_t                   q_info,
	input  logic [$clog2(LOCAL_RAM_DEPTH)-1:0] q_idx,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output z80bd_pkg::info_t                   out_info,
	output logic [7:0]                         read_data
);
	import z80bd_pkg::*;

	logic [7:0] ram [LOCAL_RAM_DEPTH];
	logic [7:0] ram_rd_q;
	info_t      info_s1;
	logic       valid_s1;

	// Advance when the output stage is free or being drained.
	assign pop = !q_empty && (!valid_s1 || out_ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_info.ram_wr) begin
				ram[q_idx] <= q_info.forward_data;
			end
			ram_rd_q <= ram[q_idx];
			info_s1  <= q_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign out_valid = valid_s1;
	assign out_info  = info_s1;
	assign read_data = info_s1.ram_rd ? ram_rd_q : 8'd0;

endmodule

// File: sv/z80_bus_decoder_with_bank_window_top.sv
// Sound-CPU bus decoder with a banked window onto the main bus.
// Input channel (in_valid/in_ready): one bus access per item, opcode 0 read,
// 1 write, with address and write_data. Output channel (out_valid/out_ready):
// one result item per access: target, main_address, to_cd_map, read_data,
// forward_data. Configuration: cfg_we with cfg_index 0 fm_enable,
// 1 psg_enable, 2 cd_mode; write only while no item is in flight.
// An accepted item goes to a queue entry, then to the output register, which
// raises out_valid; one item per cycle while out_ready is high. The front
// decodes and updates the bank register at accept, a 4-entry queue follows,
// and the back does the single-port local RAM access and holds the result in
// the output register.
// When the receiver stalls, the output register holds its item and the queue
// fills; in_ready drops once all 4 queue entries are taken.
// Reset empties the queue and output stage, clears the bank register and
// sets fm_enable 1, psg_enable 1, cd_mode 0. Local RAM is not cleared: read
// only entries written since reset.
module z80_bus_decoder_with_bank_window_top #(
	parameter int LOCAL_RAM_DEPTH = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [z80bd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                            cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [15:0]                     address,
	input  logic [7:0]                      write_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      target,
	output logic [23:0]                     main_address,
	output logic                            to_cd_map,
	output logic [7:0]                      read_data,
	output logic [7:0]                      forward_data
);
	import z80bd_pkg::*;

	localparam int IW = $clog2(LOCAL_RAM_DEPTH);
	localparam int QW = $bits(info_t) + IW;

	logic          push, pop, q_full, q_empty;
	info_t         f_info, q_info, o_info;
	logic [IW-1:0] f_idx, q_idx;
	logic [QW-1:0] q_rdata;

	z80bd_front #(.LOCAL_RAM_DEPTH(LOCAL_RAM_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.address    (address),
		.write_data (write_data),
		.q_full     (q_full),
		.push       (push),
		.info       (f_info),
		.ram_idx    (f_idx)
	);

	z80bd_queue #(.DEPTH(QUEUE_DEPTH), .W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_info, f_idx}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_info = info_t'(q_rdata[QW-1:IW]);
	assign q_idx  = q_rdata[IW-1:0];

	z80bd_back #(.LOCAL_RAM_DEPTH(LOCAL_RAM_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_info    (q_info),
		.q_idx     (q_idx),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_info  (o_info),
		.read_data (read_data)
	);

	assign target       = o_info.target;
	assign main_address = o_info.main_address;
	assign to_cd_map    = o_info.to_cd_map;
	assign forward_data = o_info.forward_data;

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !q_empty)
		else $error("accepted item did not reach the queue");

	a_window_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_MAIN |-> main_address == 24'd0 && !to_cd_map)
		else $error("main address outside a window access");

	a_dropped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == TGT_OFF || target == TGT_BAD)
		|-> read_data == 8'd0 && forward_data == 8'd0)
		else $error("dropped access carries data");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !pop)
		else $error("pop from empty queue");

endmodule
